@@ design/shelf_atlas_packer_unit_assert.svh @@
// Assertion macros for the shelf atlas packer checker
`ifndef SHELF_ATLAS_PACKER_UNIT_ASSERT_SVH
`define SHELF_ATLAS_PACKER_UNIT_ASSERT_SVH

// same-cycle implication, quiet while reset is asserted
`define SAP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define SAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sap_pkg.sv @@
// Shared widths, register indexes and result type for the shelf atlas packer
package sap_pkg;

    localparam int DIM_W  = 15;
    localparam int PAD_W  = 8;
    localparam int PAGE_W = 8;
    localparam int SUM_W  = 18;
    localparam int CFG_W  = 15;
    localparam int IDX_W  = 1;

    typedef enum logic [IDX_W-1:0] {
        CFG_CANVAS_SIZE = 1'b0,
        CFG_PAD_TEXELS  = 1'b1
    } cfg_index_t;

    localparam logic [DIM_W-1:0] CANVAS_RESET = 15'd1024;
    localparam logic [PAD_W-1:0] PAD_RESET    = 8'd2;

    typedef struct packed {
        logic [DIM_W-1:0]  pos_x;
        logic [DIM_W-1:0]  pos_y;
        logic [PAGE_W-1:0] page_index;
        logic              too_large;
    } result_t;

endpackage

@@ design/shelf_atlas_packer_unit.sv @@
// Next-fit shelf packer that places rectangles on square atlas pages
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid, in_stall, rect_width/height, start    | beat in
//   out     | out_valid, out_stall, pos_x/y, page_index, flag | beat out
//   cfg     | cfg_we, cfg_index, cfg_data                    | write only
//
// One rectangle per cycle unless in_stall; a placement is one pass of add/compare
// logic on the four shelf registers; the result is registered in the output stage.
// A two-entry output stage (output register plus skid) keeps input accepting
// while a result waits; in_stall rises only when both entries hold beats.
// Reset clears the shelf state, page count and output stage, and restores
// canvas_size to 1024 and pad_texels to 2.
module shelf_atlas_packer_unit #(
    parameter int MAX_PAGES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sap_pkg::DIM_W-1:0]   rect_width,
    input  logic [sap_pkg::DIM_W-1:0]   rect_height,
    input  logic                        start_batch,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sap_pkg::DIM_W-1:0]   pos_x,
    output logic [sap_pkg::DIM_W-1:0]   pos_y,
    output logic [sap_pkg::PAGE_W-1:0]  page_index,
    output logic                        too_large,
    input  logic                        cfg_we,
    input  logic [sap_pkg::IDX_W-1:0]   cfg_index,
    input  logic [sap_pkg::CFG_W-1:0]   cfg_data
);

    localparam int DW = sap_pkg::DIM_W;
    localparam int SW = sap_pkg::SUM_W;
    localparam int PW = sap_pkg::PAGE_W;
    localparam logic [PW-1:0] PAGE_CAP =
        (MAX_PAGES - 1 > 255) ? 8'd255 : PW'(MAX_PAGES - 1);

    logic [DW-1:0]         canvas_size_reg;
    logic [sap_pkg::PAD_W-1:0] pad_texels_reg;

    logic [DW-1:0] cursor_x_reg, cursor_x_next;
    logic [DW-1:0] shelf_y_reg, shelf_y_next;
    logic [DW-1:0] shelf_height_reg, shelf_height_next;
    logic [PW-1:0] page_number_reg, page_number_next;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    sap_pkg::result_t out_data_reg, out_data_next;
    sap_pkg::result_t skid_data_reg, skid_data_next;
    sap_pkg::result_t res;

    logic          accept;
    logic          take;
    logic [SW-1:0] w_ext, h_ext, pad_ext, cv_ext;
    logic [SW-1:0] cx0, sy0, sh0;
    logic [SW-1:0] cx1, sy1, sh1;
    logic [SW-1:0] cx2, sh2, sy2, px, py;
    logic [PW-1:0] pg0, pg1, pg2;
    logic          too, brk, open1, open2;

    assign accept = in_valid && !skid_valid_reg;
    assign take   = out_valid_reg && !out_stall;

    always_comb
    begin
        w_ext   = SW'(rect_width);
        h_ext   = SW'(rect_height);
        pad_ext = SW'(pad_texels_reg);
        cv_ext  = SW'(canvas_size_reg);

        cx0 = start_batch ? '0 : SW'(cursor_x_reg);
        sy0 = start_batch ? '0 : SW'(shelf_y_reg);
        sh0 = start_batch ? '0 : SW'(shelf_height_reg);
        pg0 = start_batch ? '0 : page_number_reg;

        too = (w_ext + pad_ext > cv_ext) || (h_ext + pad_ext > cv_ext);

        // break to a new shelf
        brk   = cx0 + w_ext + pad_ext > cv_ext;
        cx1   = brk ? '0 : cx0;
        sy1   = brk ? sy0 + sh0 + pad_ext : sy0;
        sh1   = brk ? '0 : sh0;
        open1 = brk && (sy1 + pad_ext > cv_ext);
        pg1   = pg0;
        if (open1)
        begin
            cx1 = '0;
            sy1 = '0;
            sh1 = '0;
            pg1 = (pg0 < PAGE_CAP) ? pg0 + 1'b1 : pg0;
        end

        // place on the shelf
        px  = cx1 + pad_ext;
        py  = sy1 + pad_ext;
        cx2 = cx1 + w_ext + pad_ext;
        sh2 = (h_ext > sh1) ? h_ext : sh1;
        sy2 = sy1;
        pg2 = pg1;

        // restart on a fresh page on overflow
        open2 = sy1 + sh2 + pad_ext > cv_ext;
        if (open2)
        begin
            px  = pad_ext;
            py  = pad_ext;
            cx2 = w_ext + pad_ext;
            sh2 = h_ext;
            sy2 = '0;
            pg2 = (pg1 < PAGE_CAP) ? pg1 + 1'b1 : pg1;
        end

        if (too)
        begin
            cursor_x_next     = cx0[DW-1:0];
            shelf_y_next      = sy0[DW-1:0];
            shelf_height_next = sh0[DW-1:0];
            page_number_next  = pg0;
            res.pos_x         = '0;
            res.pos_y         = '0;
            res.page_index    = pg0;
            res.too_large     = 1'b1;
        end
        else
        begin
            cursor_x_next     = cx2[DW-1:0];
            shelf_y_next      = sy2[DW-1:0];
            shelf_height_next = sh2[DW-1:0];
            page_number_next  = pg2;
            res.pos_x         = px[DW-1:0];
            res.pos_y         = py[DW-1:0];
            res.page_index    = pg2;
            res.too_large     = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take || !out_valid_reg)
        begin
            // refill output from skid first, else from the new beat
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = res;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_size_reg  <= sap_pkg::CANVAS_RESET;
            pad_texels_reg   <= sap_pkg::PAD_RESET;
            cursor_x_reg     <= '0;
            shelf_y_reg      <= '0;
            shelf_height_reg <= '0;
            page_number_reg  <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (sap_pkg::cfg_index_t'(cfg_index))
                    sap_pkg::CFG_CANVAS_SIZE: canvas_size_reg <= cfg_data;
                    sap_pkg::CFG_PAD_TEXELS:
                        pad_texels_reg <= cfg_data[sap_pkg::PAD_W-1:0];
                    default: canvas_size_reg <= canvas_size_reg;
                endcase
            end
            if (accept)
            begin
                cursor_x_reg     <= cursor_x_next;
                shelf_y_reg      <= shelf_y_next;
                shelf_height_reg <= shelf_height_next;
                page_number_reg  <= page_number_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_stall   = skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign pos_x      = out_data_reg.pos_x;
    assign pos_y      = out_data_reg.pos_y;
    assign page_index = out_data_reg.page_index;
    assign too_large  = out_data_reg.too_large;

endmodule

@@ design/sap_checker.sv @@
// Port-level checker for the shelf atlas packer and its bind
`include "shelf_atlas_packer_unit_assert.svh"

module sap_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [sap_pkg::DIM_W-1:0]   pos_x,
    input logic [sap_pkg::DIM_W-1:0]   pos_y,
    input logic [sap_pkg::PAGE_W-1:0]  page_index,
    input logic                        too_large
);

    `SAP_ASSERT_SAME(a_stall_needs_out, in_stall, out_valid, "in_stall without a held beat")
    `SAP_ASSERT_NEXT(a_accept_to_out, in_valid && !in_stall, out_valid, "accepted beat lost")
    `SAP_ASSERT_SAME(a_too_large_zero, out_valid && too_large, pos_x == '0 && pos_y == '0, "too_large beat has nonzero position")
    `SAP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pos_x) && $stable(pos_y) && $stable(page_index) && $stable(too_large), "stalled beat changed")

endmodule

bind shelf_atlas_packer_unit sap_checker u_sap_checker (.*);
